// ===== rtl/wsp_pkg.sv =====
package wsp_pkg;

    // Input beat: one world point, signed Q16.16
    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } wsp_in_t;

    // Output beat: screen position in signed Q16.8 pixels
    typedef struct packed {
        logic               visible;
        logic        [1:0]  status;
        logic signed [23:0] screen_x;
        logic signed [23:0] screen_y;
    } wsp_out_t;

    localparam int COORD_W = 32;
    localparam int SIZE_W  = 14;
    localparam int K_W     = SIZE_W + 7;
    localparam int QBITS   = 24;
    localparam int SCR_W   = 24;

    localparam logic [1:0] STATUS_VISIBLE = 2'd0;
    localparam logic [1:0] STATUS_BEHIND  = 2'd1;
    localparam logic [1:0] STATUS_X_OUT   = 2'd2;
    localparam logic [1:0] STATUS_Y_OUT   = 2'd3;

    localparam logic [3:0] REG_ROW0_01 = 4'd0;
    localparam logic [3:0] REG_ROW0_23 = 4'd1;
    localparam logic [3:0] REG_ROW1_01 = 4'd2;
    localparam logic [3:0] REG_ROW1_23 = 4'd3;
    localparam logic [3:0] REG_ROW3_01 = 4'd4;
    localparam logic [3:0] REG_ROW3_23 = 4'd5;
    localparam logic [3:0] REG_WIDTH   = 4'd6;
    localparam logic [3:0] REG_HEIGHT  = 4'd7;

    localparam int W_BEHIND_MAX = 655;

endpackage

// ===== rtl/wsp_transform.sv =====
module wsp_transform #(
    parameter int COEF_WIDTH = 32,
    parameter int SUM_W      = COEF_WIDTH + 18
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  wsp_pkg::wsp_in_t             in_data,
    input  logic signed [COEF_WIDTH-1:0] coef [3][4],
    output logic                         out_valid,
    output logic signed [SUM_W-1:0]      sum [3]
);
    import wsp_pkg::*;

    localparam int PROD_W = COEF_WIDTH + COORD_W;

    logic signed [COORD_W-1:0] pt [3];
    logic signed [PROD_W-1:0]  prod_reg [3][3];
    logic signed [SUM_W-1:0]   sum_reg [3];
    logic signed [SUM_W-1:0]   sum_next [3];
    logic                      va_reg;
    logic                      vb_reg;

    assign pt[0] = in_data.point_x;
    assign pt[1] = in_data.point_y;
    assign pt[2] = in_data.point_z;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    // Stage A: nine coefficient products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    prod_reg[r][c] <= PROD_W'(coef[r][c]) * PROD_W'(pt[c]);
        end
    end

    // Stage B: floor each product to 16 fraction bits and add column 3
    always_comb
    begin
        for (int r = 0; r < 3; r++)
            sum_next[r] = SUM_W'(prod_reg[r][0] >>> 16)
                        + SUM_W'(prod_reg[r][1] >>> 16)
                        + SUM_W'(prod_reg[r][2] >>> 16)
                        + SUM_W'(coef[r][3]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            sum_reg <= sum_next;
    end

    assign out_valid = vb_reg;
    assign sum       = sum_reg;

endmodule

// ===== rtl/wsp_scale_div.sv =====
module wsp_scale_div #(
    parameter int MAG_W = 51,
    parameter int DEN_W = 50
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic [MAG_W-1:0]         mag,
    input  logic                     neg,
    input  logic [wsp_pkg::K_W-1:0]  k,
    input  logic [DEN_W-1:0]         den,
    output logic [wsp_pkg::QBITS-1:0] quo,
    output logic                     inexact,
    output logic                     neg_out,
    output logic                     sat
);
    import wsp_pkg::*;

    localparam int NUM_W = MAG_W + K_W;
    localparam int R_W   = ((NUM_W > DEN_W + QBITS) ? NUM_W : DEN_W + QBITS) + 1;

    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] dd_reg;
    logic             nd_reg;

    logic [R_W-1:0]   rem_reg [QBITS+1];
    logic [QBITS-1:0] q_reg   [QBITS+1];
    logic [DEN_W-1:0] d_reg   [QBITS+1];
    logic             n_reg   [QBITS+1];
    logic             s_reg   [QBITS+1];

    // Stage D: scale numerator by viewport size
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg <= NUM_W'(mag) * NUM_W'(k);
            dd_reg  <= den;
            nd_reg  <= neg;
        end
    end

    // Stage E: flag quotients that do not fit in QBITS bits
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= R_W'(num_reg);
            q_reg[0]   <= '0;
            d_reg[0]   <= dd_reg;
            n_reg[0]   <= nd_reg;
            s_reg[0]   <= R_W'(num_reg) >= (R_W'(dd_reg) << QBITS);
        end
    end

    // One quotient bit per stage, most significant first
    for (genvar s = 1; s <= QBITS; s++)
    begin : g_step
        logic [R_W-1:0] dsh;
        logic           take;

        assign dsh  = R_W'(d_reg[s-1]) << (QBITS - s);
        assign take = rem_reg[s-1] >= dsh;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= take ? rem_reg[s-1] - dsh : rem_reg[s-1];
                q_reg[s]   <= {q_reg[s-1][QBITS-2:0], take};
                d_reg[s]   <= d_reg[s-1];
                n_reg[s]   <= n_reg[s-1];
                s_reg[s]   <= s_reg[s-1];
            end
        end
    end

    assign quo     = q_reg[QBITS];
    assign inexact = rem_reg[QBITS] != '0;
    assign neg_out = n_reg[QBITS];
    assign sat     = s_reg[QBITS];

endmodule

// ===== rtl/world_to_screen_projection_core.sv =====
// Throughput: one point per cycle unless the output stalls; the nine
// products, the scale multiply and the 24 restoring divider stages are
// all fully pipelined.
// A stalled output freezes the whole pipeline in place.
// Reset (rst_n, asynchronous, active low) empties the pipeline and loads the
// identity matrix rows with w = z and a 1920 x 1080 viewport.
module world_to_screen_projection_core #(
    parameter int COEF_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  wsp_pkg::wsp_in_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output wsp_pkg::wsp_out_t out_data,
    input  logic              cfg_we,
    input  logic [3:0]        cfg_index,
    input  logic [63:0]       cfg_data
);
    import wsp_pkg::*;

    localparam int SUM_W   = COEF_WIDTH + 18;
    localparam int MAG_W   = SUM_W + 1;
    localparam int DIV_LAT = QBITS + 2;

    logic [63:0]       mat_reg [6];
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;

    logic signed [COEF_WIDTH-1:0] coef [3][4];
    logic                         en;
    logic                         tv;
    logic signed [SUM_W-1:0]      sum [3];

    logic                vc_reg;
    logic                bc_reg;
    logic [MAG_W-1:0]    mx_reg, my_reg;
    logic                nx_reg, ny_reg;
    logic [SUM_W-1:0]    den_reg;
    logic signed [MAG_W-1:0] tx, ty;

    logic                dv_reg [DIV_LAT];
    logic                db_reg [DIV_LAT];

    logic [QBITS-1:0]    qx, qy;
    logic                ix, iy, ngx, ngy, sx_sat, sy_sat;

    logic                out_valid_reg;
    wsp_out_t            out_reg;
    wsp_out_t            out_next;
    logic signed [SCR_W-1:0] scr_x, scr_y;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_reg[0] <= 64'h0000_0000_0001_0000;
            mat_reg[1] <= 64'h0;
            mat_reg[2] <= 64'h0001_0000_0000_0000;
            mat_reg[3] <= 64'h0;
            mat_reg[4] <= 64'h0;
            mat_reg[5] <= 64'h0000_0000_0001_0000;
            width_reg  <= SIZE_W'(1920);
            height_reg <= SIZE_W'(1080);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROW0_01: mat_reg[0] <= cfg_data;
                REG_ROW0_23: mat_reg[1] <= cfg_data;
                REG_ROW1_01: mat_reg[2] <= cfg_data;
                REG_ROW1_23: mat_reg[3] <= cfg_data;
                REG_ROW3_01: mat_reg[4] <= cfg_data;
                REG_ROW3_23: mat_reg[5] <= cfg_data;
                REG_WIDTH:   width_reg  <= cfg_data[SIZE_W-1:0];
                REG_HEIGHT:  height_reg <= cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Unpack coefficients: even column low half, odd column high half
    for (genvar r = 0; r < 3; r++)
    begin : g_row
        for (genvar c = 0; c < 4; c++)
        begin : g_col
            assign coef[r][c] = mat_reg[r*2 + c/2][(c%2)*32 +: COEF_WIDTH];
        end
    end

    // Advance unless the output beat is held
    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    wsp_transform #(
        .COEF_WIDTH (COEF_WIDTH),
        .SUM_W      (SUM_W)
    ) u_transform (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .coef      (coef),
        .out_valid (tv),
        .sum       (sum)
    );

    // Stage C: viewport numerators, sign split and behind test
    assign tx = MAG_W'(sum[2]) + MAG_W'(sum[0]);
    assign ty = MAG_W'(sum[2]) - MAG_W'(sum[1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vc_reg <= 1'b0;
        else if (en)
            vc_reg <= tv;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bc_reg  <= sum[2] <= SUM_W'(W_BEHIND_MAX);
            nx_reg  <= tx[MAG_W-1];
            ny_reg  <= ty[MAG_W-1];
            mx_reg  <= tx[MAG_W-1] ? MAG_W'(-tx) : MAG_W'(tx);
            my_reg  <= ty[MAG_W-1] ? MAG_W'(-ty) : MAG_W'(ty);
            den_reg <= sum[2];
        end
    end

    wsp_scale_div #(.MAG_W (MAG_W), .DEN_W (SUM_W)) u_div_x (
        .clk     (clk),
        .en      (en),
        .mag     (mx_reg),
        .neg     (nx_reg),
        .k       ({width_reg, 7'b0}),
        .den     (den_reg),
        .quo     (qx),
        .inexact (ix),
        .neg_out (ngx),
        .sat     (sx_sat)
    );

    wsp_scale_div #(.MAG_W (MAG_W), .DEN_W (SUM_W)) u_div_y (
        .clk     (clk),
        .en      (en),
        .mag     (my_reg),
        .neg     (ny_reg),
        .k       ({height_reg, 7'b0}),
        .den     (den_reg),
        .quo     (qy),
        .inexact (iy),
        .neg_out (ngy),
        .sat     (sy_sat)
    );

    // Carry valid and behind flag alongside the dividers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_LAT; i++)
                dv_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            dv_reg[0] <= vc_reg;
            for (int i = 1; i < DIV_LAT; i++)
                dv_reg[i] <= dv_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            db_reg[0] <= bc_reg;
            for (int i = 1; i < DIV_LAT; i++)
                db_reg[i] <= db_reg[i-1];
        end
    end

    // Round toward minus infinity and saturate to 24 bits
    function automatic logic signed [SCR_W-1:0] fix_q(
        input logic [QBITS-1:0] q,
        input logic             inx,
        input logic             ng,
        input logic             st
    );
        logic [QBITS:0] m;
        m = {1'b0, q} + (QBITS+1)'(inx);
        if (!ng)
            fix_q = (st || q[QBITS-1]) ? {1'b0, {(SCR_W-1){1'b1}}} : SCR_W'(q);
        else if (st || m > {2'b01, {(QBITS-1){1'b0}}})
            fix_q = {1'b1, {(SCR_W-1){1'b0}}};
        else
            fix_q = SCR_W'(-m);
    endfunction

    assign scr_x = fix_q(qx, ix, ngx, sx_sat);
    assign scr_y = fix_q(qy, iy, ngy, sy_sat);

    // Output stage: bound tests and status
    always_comb
    begin
        out_next          = '0;
        if (db_reg[DIV_LAT-1])
        begin
            out_next.status = STATUS_BEHIND;
        end
        else
        begin
            out_next.screen_x = scr_x;
            out_next.screen_y = scr_y;
            if (scr_x[SCR_W-1] ||
                $signed({scr_x[SCR_W-1], scr_x}) > $signed({3'b0, width_reg, 8'b0}))
                out_next.status = STATUS_X_OUT;
            else if (scr_y[SCR_W-1] ||
                $signed({scr_y[SCR_W-1], scr_y}) > $signed({3'b0, height_reg, 8'b0}))
                out_next.status = STATUS_Y_OUT;
            else
            begin
                out_next.status  = STATUS_VISIBLE;
                out_next.visible = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dv_reg[DIV_LAT-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== tb/world_to_screen_projection_checker.sv =====
`timescale 1ns / 1ps

module world_to_screen_projection_checker #(
    parameter int COEF_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  wsp_pkg::wsp_in_t  in_data,
    input  logic              out_valid,
    input  logic              out_stall,
    input  wsp_pkg::wsp_out_t out_data,
    input  logic              cfg_we,
    input  logic [3:0]        cfg_index,
    input  logic [63:0]       cfg_data,
    output int                fail_count,
    output int                pending_count,
    output int                beats_checked,
    output int                visible_seen
);
    import wsp_pkg::*;

    logic [63:0] coef_regs [6];
    logic [13:0] view_w;
    logic [13:0] view_h;
    wsp_out_t    pending_screen [$];

    // Sign-extend one coefficient half from bit COEF_WIDTH-1
    function automatic longint coef_of(int row_pair, int col);
        logic [63:0] r;
        logic [31:0] half;
        longint      v;
        r    = coef_regs[row_pair * 2 + col / 2];
        half = (col % 2) ? r[63:32] : r[31:0];
        v    = longint'(half) & ((64'd1 << COEF_WIDTH) - 1);
        if (v[COEF_WIDTH-1])
            v = v - (64'sd1 <<< COEF_WIDTH);
        return v;
    endfunction

    function automatic longint row_sum(int row_pair, longint px, longint py, longint pz);
        return ((coef_of(row_pair, 0) * px) >>> 16) + ((coef_of(row_pair, 1) * py) >>> 16)
             + ((coef_of(row_pair, 2) * pz) >>> 16) + coef_of(row_pair, 3);
    endfunction

    // floor(t * k / w), saturated to 24 bits signed
    function automatic logic signed [23:0] scaled_quotient(longint t, longint k, longint w);
        logic signed [127:0] num;
        logic signed [127:0] q;
        num = 128'(t) * 128'(k);
        q   = num / 128'(w);
        if (num < 0 && q * 128'(w) != num)
            q = q - 1;
        if (q > 128'sd8388607)
            return 24'sd8388607;
        if (q < -128'sd8388608)
            return -24'sd8388608;
        return q[23:0];
    endfunction

    function automatic wsp_out_t project_point(wsp_in_t p);
        wsp_out_t o;
        longint   w;
        longint   r0;
        longint   r1;
        longint   sx;
        longint   sy;
        o  = '0;
        w  = row_sum(2, p.point_x, p.point_y, p.point_z);
        if (w <= W_BEHIND_MAX)
        begin
            o.status = STATUS_BEHIND;
            return o;
        end
        r0 = row_sum(0, p.point_x, p.point_y, p.point_z);
        r1 = row_sum(1, p.point_x, p.point_y, p.point_z);
        o.screen_x = scaled_quotient(w + r0, longint'(view_w) * 128, w);
        o.screen_y = scaled_quotient(w - r1, longint'(view_h) * 128, w);
        sx = o.screen_x;
        sy = o.screen_y;
        if (sx < 0 || sx > longint'(view_w) * 256)
            o.status = STATUS_X_OUT;
        else if (sy < 0 || sy > longint'(view_h) * 256)
            o.status = STATUS_Y_OUT;
        else
            o.status = STATUS_VISIBLE;
        o.visible = (o.status == STATUS_VISIBLE);
        return o;
    endfunction

    assign pending_count = pending_screen.size();

    // Track config, predict input beats, compare output beats
    always @(posedge clk or negedge rst_n)
    begin
        wsp_out_t e;
        if (!rst_n)
        begin
            coef_regs[0] <= 64'd65536;
            coef_regs[1] <= 64'd0;
            coef_regs[2] <= 64'd65536 << 32;
            coef_regs[3] <= 64'd0;
            coef_regs[4] <= 64'd0;
            coef_regs[5] <= 64'd65536;
            view_w        <= 14'd1920;
            view_h        <= 14'd1080;
            fail_count    <= 0;
            beats_checked <= 0;
            visible_seen  <= 0;
            pending_screen.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index <= REG_ROW3_23)
                    coef_regs[cfg_index] <= cfg_data;
                else if (cfg_index == REG_WIDTH)
                    view_w <= cfg_data[13:0];
                else if (cfg_index == REG_HEIGHT)
                    view_h <= cfg_data[13:0];
            end
            if (in_valid && !in_stall)
                pending_screen.push_back(project_point(in_data));
            if (out_valid && !out_stall)
            begin
                if (pending_screen.size() == 0)
                begin
                    $error("unexpected output beat");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = pending_screen.pop_front();
                    beats_checked <= beats_checked + 1;
                    if (e.visible)
                        visible_seen <= visible_seen + 1;
                    if (e != out_data)
                    begin
                        fail_count <= fail_count + 1;
                        if (e.visible != out_data.visible)
                            $error("visible exp %0d got %0d", e.visible, out_data.visible);
                        if (e.status != out_data.status)
                            $error("status exp %0d got %0d", e.status, out_data.status);
                        if (e.screen_x != out_data.screen_x)
                            $error("screen_x exp %0d got %0d", e.screen_x, out_data.screen_x);
                        if (e.screen_y != out_data.screen_y)
                            $error("screen_y exp %0d got %0d", e.screen_y, out_data.screen_y);
                    end
                end
            end
        end
    end
endmodule

// ===== tb/world_to_screen_projection_core_test.sv =====
`timescale 1ns / 1ps

module world_to_screen_projection_core_test;
    import wsp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    wsp_in_t     in_data;
    logic        out_valid;
    logic        out_stall;
    wsp_out_t    out_data;
    logic        cfg_we;
    logic [3:0]  cfg_index;
    logic [63:0] cfg_data;
    int          fail_count;
    int          pending_count;
    int          beats_checked;
    int          visible_seen;
    int          idle_cycles;
    bit          calm;

    world_to_screen_projection_core dut (.*);

    world_to_screen_projection_checker checker_inst (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver stall bursts, none in the calm tail
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 9) == 0)
            begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 15)) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    // Watchdog on cycles with no accepted beat
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("world_to_screen_projection_core_test: errors");
            $finish;
        end
    end

    task automatic write_reg(logic [3:0] idx, logic [63:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Hold one point until accepted; optional source gap first
    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        if (!calm && $urandom_range(0, 9) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = '{point_x: x, point_y: y, point_z: z};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic logic [31:0] random_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($urandom_range(0, 20 << 16)) - (10 << 16);
            default: return 32'($urandom_range(0, 4 << 16)) - (2 << 16);
        endcase
    endfunction

    function automatic logic [31:0] random_coef();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'($urandom_range(0, 4 << 16)) - (2 << 16);
            2: return 32'd0;
            default: return 32'd65536;
        endcase
    endfunction

    // Random points, mostly near the view volume so projections land inside
    task automatic random_points(int count);
        int m;
        for (int i = 0; i < count; i++)
        begin
            m = $urandom_range(0, 9);
            send_point(random_coord(m == 0 ? 0 : 2), random_coord(m == 0 ? 0 : 2),
                       m < 2 ? random_coord(m) : 32'($urandom_range(1 << 14, 8 << 16)));
        end
    endtask

    initial
    begin
        logic [31:0] corners [5];
        corners = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0001_0000};
        calm      = 1'b0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_ROW0_01;
        cfg_data  = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset matrix, w = z
        send_point(32'h0, 32'h0, 32'd655);               // w exactly at behind limit
        send_point(32'h0, 32'h0, 32'd656);               // just in front
        send_point(32'h0, 32'h0, 32'h0001_0000);         // centre
        send_point(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000); // right/bottom edge
        send_point(32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000); // left/top edge
        send_point(32'h0002_0000, 32'h0, 32'h0001_0000); // x outside
        send_point(32'h0, 32'h0002_0000, 32'h0001_0000); // y outside
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'd700); // saturation
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'd700);
        send_point(32'h0, 32'h0, 32'hFFFF_0000);         // negative w
        foreach (corners[i])
            send_point(corners[i], corners[(i + 1) % 5], corners[(i + 2) % 5]);
        wait_drained();

        // Extreme viewport sizes and coefficients
        write_reg(REG_WIDTH, 64'd8192);
        write_reg(REG_HEIGHT, 64'd1);
        write_reg(REG_ROW0_23, {32'h7FFF_FFFF, 32'h8000_0000});
        write_reg(REG_ROW1_23, 64'hFFFF_FFFF_FFFF_FFFF);
        random_points(40);
        wait_drained();
        write_reg(REG_WIDTH, 64'd0);
        write_reg(REG_HEIGHT, 64'd8192);
        write_reg(REG_ROW0_23, 64'd0);
        write_reg(REG_ROW1_23, 64'd0);
        send_point(32'h0, 32'h0, 32'h0001_0000);
        random_points(40);
        wait_drained();
        write_reg(4'd9, 64'hFFFF_FFFF_FFFF_FFFF);        // unused index, ignored

        // Random phases with random matrices
        for (int phase = 0; phase < 6; phase++)
        begin
            write_reg(REG_ROW0_01, {random_coef(), random_coef()});
            write_reg(REG_ROW1_01, {random_coef(), random_coef()});
            write_reg(REG_ROW0_23, {random_coef(), 32'd0});
            write_reg(REG_ROW1_23, {random_coef(), 32'd0});
            write_reg(REG_ROW3_01, phase % 2 ? {random_coef(), random_coef()} : 64'd0);
            write_reg(REG_ROW3_23, {random_coef(), 32'd65536});
            write_reg(REG_WIDTH, 64'($urandom_range(1, 8192)));
            write_reg(REG_HEIGHT, 64'($urandom_range(1, 8192)));
            random_points(200);
            wait_drained();
        end

        // Reset matrix again, calm tail
        write_reg(REG_ROW0_01, 64'd65536);
        write_reg(REG_ROW1_01, 64'd65536 << 32);
        write_reg(REG_ROW0_23, 64'd0);
        write_reg(REG_ROW1_23, 64'd0);
        write_reg(REG_ROW3_01, 64'd0);
        write_reg(REG_ROW3_23, 64'd65536);
        write_reg(REG_WIDTH, 64'd1920);
        write_reg(REG_HEIGHT, 64'd1080);
        calm = 1'b1;
        random_points(150);
        wait_drained();

        $display("Checked %0d output beats, %0d visible, across ten matrix and viewport settings.",
                 beats_checked, visible_seen);
        if (fail_count == 0)
            $display("world_to_screen_projection_core_test: clean");
        else
            $display("world_to_screen_projection_core_test: errors");
        $finish;
    end
endmodule

// ===== world_to_screen_projection_core.f =====
rtl/wsp_pkg.sv
rtl/wsp_transform.sv
rtl/wsp_scale_div.sv
rtl/world_to_screen_projection_core.sv
tb/world_to_screen_projection_checker.sv
tb/world_to_screen_projection_core_test.sv
